// ===== rtl/lzss_ring_window_decompressor_macros.svh =====
// Assertion macros shared by the LZSS decompressor RTL.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef LZSS_RING_WINDOW_DECOMPRESSOR_MACROS_SVH
`define LZSS_RING_WINDOW_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication.
`define LZSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzss assertion failed");

// Next-cycle implication.
`define LZSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzss assertion failed");

`endif

// ===== rtl/lzss_pkg.sv =====
// Shared constants and controller/datapath command and status types
// for the LZSS ring-window decompressor. No dependencies.
package lzss_pkg;

  localparam int WIN_SIZE  = 4096;
  localparam int WIN_AW    = $clog2(WIN_SIZE);
  localparam int MAX_COPY  = 18;
  localparam int MIN_MATCH = 3;
  localparam int CNT_W     = 32;
  localparam int LEN_W     = $clog2(MAX_COPY + 1);

  localparam logic [WIN_AW-1:0] WP_INIT = WIN_AW'(WIN_SIZE - MAX_COPY);

  // Controller -> datapath commands
  typedef struct packed {
    logic clear;    // stream start: reset window fill and counters
    logic hdr;      // take a length header byte
    logic flag;     // take a flag byte
    logic dlow;     // take the low distance byte of a pair
    logic lit;      // emit the input byte as a literal
    logic cp_load;  // take the high pair byte, load distance and length
    logic cp_rd;    // read the window at the copy source
    logic cp_wr;    // emit and store the copied byte
    logic adv;      // advance to the next flag bit
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic hdr_last;  // this header byte is the final one
    logic hdr_zero;  // declared length ends up zero
    logic flag_bit;  // current flag bit
    logic bit_last;  // current flag bit is bit 7
    logic reached;   // next emitted byte completes the declared length
    logic cp_last;   // one copy byte left
    logic out_free;  // output register can take an item this cycle
  } sts_t;

endpackage

// ===== rtl/lzss_if.sv =====
// Valid/ready channel interfaces for the LZSS decompressor.
// Input carries compressed bytes, output carries decoded bytes.
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  output ready);
endinterface

// ===== rtl/lzss_ctrl.sv =====
// Decoder state machine: tracks the stream phase and sequences window copies.
// Depends on lzss_pkg (cmd_t, sts_t).
module lzss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stream_start,
  output logic          in_ready,
  input  lzss_pkg::sts_t sts,
  output lzss_pkg::cmd_t cmd
);

  localparam logic [2:0] S_HEADER  = 3'd0;
  localparam logic [2:0] S_FLAG    = 3'd1;
  localparam logic [2:0] S_ITEM    = 3'd2;
  localparam logic [2:0] S_PAIR_HI = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;
  localparam logic [2:0] S_CP_RD   = 3'd5;
  localparam logic [2:0] S_CP_WR   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] eff_st;
  logic [2:0] adv_st;
  logic       wait_st;
  logic       acc;

  assign wait_st  = state_r inside {S_HEADER, S_FLAG, S_ITEM, S_PAIR_HI, S_DONE};
  assign in_ready = wait_st && sts.out_free;
  assign acc      = in_valid && in_ready;
  // a start mark overrides whatever phase we were in
  assign eff_st   = in_stream_start ? S_HEADER : state_r;
  assign adv_st   = sts.reached ? S_DONE : (sts.bit_last ? S_FLAG : S_ITEM);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    if (wait_st) begin
      if (acc) begin
        cmd.clear = in_stream_start;
        case (eff_st)
          S_HEADER: begin
            cmd.hdr = 1'b1;
            if (!in_stream_start && sts.hdr_last) begin
              state_nxt = sts.hdr_zero ? S_DONE : S_FLAG;
            end else begin
              state_nxt = S_HEADER;
            end
          end
          S_FLAG: begin
            cmd.flag  = 1'b1;
            state_nxt = S_ITEM;
          end
          S_ITEM: begin
            if (sts.flag_bit) begin
              cmd.dlow  = 1'b1;
              state_nxt = S_PAIR_HI;
            end else begin
              cmd.lit   = 1'b1;
              cmd.adv   = 1'b1;
              state_nxt = adv_st;
            end
          end
          S_PAIR_HI: begin
            cmd.cp_load = 1'b1;
            state_nxt   = S_CP_RD;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
    end else begin
      case (state_r)
        S_CP_RD: begin
          cmd.cp_rd = 1'b1;
          state_nxt = S_CP_WR;
        end
        S_CP_WR: begin
          // hold the read data until the output register frees up
          if (sts.out_free) begin
            cmd.cp_wr = 1'b1;
            if (sts.cp_last || sts.reached) begin
              cmd.adv   = 1'b1;
              state_nxt = adv_st;
            end else begin
              state_nxt = S_CP_RD;
            end
          end
        end
        default: begin
          state_nxt = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/lzss_dp.sv =====
// Decoder datapath: 4 KiB ring window, header/flag/pair registers, counters
// and the output register. Depends on lzss_pkg.
module lzss_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_data_byte,
  input  lzss_pkg::cmd_t  cmd,
  output lzss_pkg::sts_t  sts,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_run_last,
  output logic           out_stream_done
);

  localparam int AW = lzss_pkg::WIN_AW;
  localparam int CW = lzss_pkg::CNT_W;
  localparam int LW = lzss_pkg::LEN_W;

  logic [7:0] win_mem [lzss_pkg::WIN_SIZE];

  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW:0]   fill_r, fill_nxt;     // writes since stream start, saturates at full
  logic [CW-1:0] prod_r, prod_nxt;
  logic [CW-1:0] decl_r, decl_nxt;
  logic [1:0]    hidx_r, hidx_nxt;
  logic [7:0]    flag_r, flag_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [7:0]    dlow_r, dlow_nxt;
  logic [AW-1:0] dist_r;
  logic [LW-1:0] rem_r;
  logic [7:0]    rd_q_r;
  logic          rd_ok_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_run_last_r;
  logic          out_stream_done_r;

  logic          emit;
  logic [7:0]    emit_byte;
  logic [CW-1:0] prod_inc;
  logic          reached;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_ofs;
  logic          rd_ok;
  logic          out_free;

  assign emit      = cmd.lit || cmd.cp_wr;
  // entries not yet written since stream start read as zero
  assign emit_byte = cmd.lit ? in_data_byte : (rd_ok_r ? rd_q_r : 8'h00);
  assign prod_inc  = prod_r + CW'(1);
  assign reached   = (prod_inc == decl_r);
  assign out_free  = !out_valid_r || out_ready;

  assign rd_addr = wp_r - dist_r;
  // writes run sequentially from the start pointer, so the source was written
  // iff its offset from the start is below the fill count
  assign rd_ofs  = fill_r[AW-1:0] - dist_r;
  assign rd_ok   = fill_r[AW] || (rd_ofs < fill_r[AW-1:0]);

  always_comb begin
    sts          = '0;
    sts.hdr_last = (hidx_r == 2'd3);
    sts.hdr_zero = (decl_r[CW-9:0] == '0) && (in_data_byte == 8'h00);
    sts.flag_bit = flag_r[bit_r];
    sts.bit_last = (bit_r == 3'd7);
    sts.reached  = reached;
    sts.cp_last  = (rem_r == LW'(1));
    sts.out_free = out_free;
  end

  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    prod_nxt = prod_r;
    decl_nxt = decl_r;
    hidx_nxt = hidx_r;
    flag_nxt = flag_r;
    bit_nxt  = bit_r;
    dlow_nxt = dlow_r;
    if (cmd.clear) begin
      wp_nxt   = lzss_pkg::WP_INIT;
      fill_nxt = '0;
      prod_nxt = '0;
      decl_nxt = {{(CW-8){1'b0}}, in_data_byte};
      hidx_nxt = 2'd1;
      flag_nxt = '0;
      bit_nxt  = '0;
      dlow_nxt = '0;
    end else begin
      if (cmd.hdr) begin
        decl_nxt = decl_r | ({{(CW-8){1'b0}}, in_data_byte} << {hidx_r, 3'b000});
        hidx_nxt = hidx_r + 2'd1;
      end
      if (cmd.flag) begin
        flag_nxt = in_data_byte;
        bit_nxt  = '0;
      end
      if (cmd.dlow) begin
        dlow_nxt = in_data_byte;
      end
      if (emit) begin
        wp_nxt   = wp_r + AW'(1);
        prod_nxt = prod_inc;
        if (!fill_r[AW]) begin
          fill_nxt = fill_r + (AW+1)'(1);
        end
      end
      if (cmd.adv) begin
        bit_nxt = bit_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= lzss_pkg::WP_INIT;
      fill_r      <= '0;
      prod_r      <= '0;
      decl_r      <= '0;
      hidx_r      <= '0;
      flag_r      <= '0;
      bit_r       <= '0;
      dlow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      prod_r <= prod_nxt;
      decl_r <= decl_nxt;
      hidx_r <= hidx_nxt;
      flag_r <= flag_nxt;
      bit_r  <= bit_nxt;
      dlow_r <= dlow_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cp_load) begin
      dist_r <= {in_data_byte[3:0], dlow_r};
      rem_r  <= LW'(in_data_byte[7:4]) + LW'(lzss_pkg::MIN_MATCH);
    end else if (cmd.cp_wr) begin
      rem_r <= rem_r - LW'(1);
    end
    if (cmd.cp_rd) begin
      rd_ok_r <= rd_ok;
    end
    if (emit) begin
      out_byte_r        <= emit_byte;
      out_run_last_r    <= cmd.lit || reached || (rem_r == LW'(1));
      out_stream_done_r <= reached;
    end
  end

  // window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (emit) begin
      win_mem[wp_r] <= emit_byte;
    end
    if (cmd.cp_rd) begin
      rd_q_r <= win_mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = out_run_last_r;
  assign out_stream_done = out_stream_done_r;

endmodule

// ===== rtl/lzss_ring_window_decompressor.sv =====
// LZSS ring-window decompressor top level: controller plus datapath.
// Depends on lzss_pkg, lzss_if, lzss_ctrl, lzss_dp and the macros header.
// Usage:
//   in_ch  carries one compressed byte per item with a stream_start mark on
//          the first header byte of a stream. Four header bytes give the
//          decoded length (LSB first), then flag groups of literals and pairs.
//   out_ch carries one decoded byte per item; run_last marks the final byte
//          an input item produces, stream_done the byte that completes the
//          declared length. After that, input items are swallowed silently
//          until the next stream_start.
// Item handling:
//   A literal is taken and shows on out_ch in the cycle after. A pair-high item
//   expands into 3 to 18 bytes, fewer if the declared length ends first; each
//   byte takes a window read, then a write and emit.
// Reset and stalls:
//   Reset, like stream_start, empties the window through a fill count: no
//   clearing pass, the block takes items at once. in_ready drops while a copy
//   runs or while the output register holds an item the receiver has not
//   taken; a stalled copy simply holds its state.
`include "lzss_ring_window_decompressor_macros.svh"

module lzss_ring_window_decompressor (
  input  logic              clk,
  input  logic              rst_n,
  lzss_in_if.sink           in_ch,
  lzss_out_if.source        out_ch
);

  lzss_pkg::cmd_t cmd;
  lzss_pkg::sts_t sts;
  logic           in_ready;

  lzss_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_stream_start (in_ch.stream_start),
    .in_ready        (in_ready),
    .sts             (sts),
    .cmd             (cmd)
  );

  lzss_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_ch.data_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_byte        (out_ch.out_byte),
    .out_run_last    (out_ch.run_last),
    .out_stream_done (out_ch.stream_done)
  );

  assign in_ch.ready = in_ready;

  // never overwrite an item the receiver has not taken
  `LZSS_ASSERT_IMP(a_no_overwrite, out_ch.valid && !out_ch.ready, !(cmd.lit || cmd.cp_wr))
  // no input is taken while a copy reads or writes the window
  `LZSS_ASSERT_IMP(a_no_input_in_copy, cmd.cp_rd || cmd.cp_wr, !in_ready)
  // every window read is followed by a write phase, not another read
  `LZSS_ASSERT_NXT(a_rd_then_wr, cmd.cp_rd, !cmd.cp_rd)
  // the byte that completes the stream always closes its run
  `LZSS_ASSERT_IMP(a_done_is_last, out_ch.valid && out_ch.stream_done, out_ch.run_last)

endmodule

// ===== bench/lzss_ring_window_decompressor_chk.sv =====
// Decode checker for the LZSS ring-window decompressor: watches both channels,
// decodes every accepted compressed byte on its own and compares decoded bytes and flags.
// Depends on lzss_pkg and the channel interfaces in lzss_if.
module lzss_ring_window_decompressor_chk (
  input  logic clk,
  input  logic rst_n,
  lzss_in_if   in_ch,
  lzss_out_if  out_ch,
  output int   errors,
  output int   backlog
);

  typedef enum logic [2:0] {ST_HEADER, ST_FLAG, ST_ITEM, ST_PAIR_HI, ST_DONE} dec_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } dec_byte_t;

  logic [7:0]                  win [lzss_pkg::WIN_SIZE];
  logic [lzss_pkg::WIN_AW-1:0] wr_ptr;
  dec_state_t                  state;
  logic [1:0]                  hdr_idx;
  logic [7:0]                  flags;
  logic [2:0]                  bit_idx;
  logic [7:0]                  dist_lo;
  logic [31:0]                 decl_len;
  logic [31:0]                 made;
  dec_byte_t                   decoded_q[$];
  int                          mismatch_count = 0;
  int                          waiting = 0;

  assign errors  = mismatch_count;
  assign backlog = waiting;

  function automatic void restart_stream();
    for (int i = 0; i < lzss_pkg::WIN_SIZE; i++) win[i] = 8'h00;
    wr_ptr   = lzss_pkg::WP_INIT;
    state    = ST_HEADER;
    hdr_idx  = '0;
    flags    = '0;
    bit_idx  = '0;
    dist_lo  = '0;
    decl_len = '0;
    made     = '0;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    dec_byte_t e;
    win[wr_ptr] = b;
    wr_ptr      = wr_ptr + 1'b1;
    made        = made + 1;
    e.data      = b;
    e.last      = 1'b0;
    e.done      = (made == decl_len);
    decoded_q.push_back(e);
  endfunction

  function automatic void next_bit();
    if (made >= decl_len) begin
      state = ST_DONE;
    end else begin
      bit_idx = bit_idx + 1'b1;
      state   = (bit_idx == 3'd0) ? ST_FLAG : ST_ITEM;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic mark);
    int                          n0;
    int unsigned                 span;
    logic [lzss_pkg::WIN_AW-1:0] offset;
    logic [lzss_pkg::WIN_AW-1:0] src;
    dec_byte_t                   tail;
    n0 = decoded_q.size();
    if (mark) restart_stream();
    case (state)
      ST_HEADER: begin
        decl_len = decl_len | (32'(b) << (8 * hdr_idx));
        hdr_idx  = hdr_idx + 1'b1;
        if (hdr_idx == 2'd0) state = (decl_len == 0) ? ST_DONE : ST_FLAG;
      end
      ST_FLAG: begin
        flags   = b;
        bit_idx = '0;
        state   = ST_ITEM;
      end
      ST_ITEM: begin
        if (!flags[bit_idx]) begin
          put_byte(b);
          next_bit();
        end else begin
          dist_lo = b;
          state   = ST_PAIR_HI;
        end
      end
      ST_PAIR_HI: begin
        offset = {b[3:0], dist_lo};
        span   = b[7:4] + lzss_pkg::MIN_MATCH;
        // source is re-read per byte so overlapping copies replicate
        for (int i = 0; i < span && made < decl_len; i++) begin
          src = wr_ptr - offset;
          put_byte(win[src]);
        end
        next_bit();
      end
      default: state = ST_DONE;
    endcase
    if (decoded_q.size() > n0) begin
      tail      = decoded_q.pop_back();
      tail.last = 1'b1;
      decoded_q.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    dec_byte_t want;
    if (!rst_n) begin
      restart_stream();
      decoded_q.delete();
    end else begin
      // retire the output first: it can only belong to earlier input items
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          $error("decoded byte %02h with nothing expected", out_ch.out_byte);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_ch.out_byte);
            mismatch_count++;
          end
          if (out_ch.run_last !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, out_ch.run_last);
            mismatch_count++;
          end
          if (out_ch.stream_done !== want.done) begin
            $error("stream_done: expected %0b, got %0b", want.done, out_ch.stream_done);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.stream_start);
    end
    waiting <= decoded_q.size();
  end

endmodule

// ===== bench/lzss_ring_window_decompressor_tb.sv =====
// Testbench top for the LZSS ring-window decompressor: clock, reset, stream
// stimulus and output stalls; checking is done by lzss_ring_window_decompressor_chk.
// Depends on lzss_if, the decompressor RTL and the checker.
module lzss_ring_window_decompressor_tb;

  logic clk;
  logic rst_n;
  logic calm;
  int   fail_count;
  int   pending;
  logic [7:0] stream_q[$];

  lzss_in_if  in_ch ();
  lzss_out_if out_ch ();

  lzss_ring_window_decompressor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lzss_ring_window_decompressor_chk chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (fail_count),
    .backlog (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL lzss_ring_window_decompressor");
    $finish;
  end

  // receiver: per item, insert a random stall unless in a calm stretch
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic mark);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.stream_start <= mark;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // send the first upto bytes of stream_q, marking the first one if asked
  task automatic play_stream(input logic mark_first, input int upto);
    for (int i = 0; i < stream_q.size() && i < upto; i++)
      send_byte(stream_q[i], mark_first && (i == 0));
  endtask

  // hold the sender until every decoded byte has been taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic void build_stream(input int unsigned total);
    int unsigned made;
    logic [7:0]  flags;
    logic [11:0] offset;
    logic [3:0]  span;
    stream_q.delete();
    for (int k = 0; k < 4; k++) stream_q.push_back(8'(total >> (8 * k)));
    made = 0;
    while (made < total) begin
      flags = 8'($urandom);
      stream_q.push_back(flags);
      for (int k = 0; k < 8 && made < total; k++) begin
        if (!flags[k]) begin
          stream_q.push_back(8'($urandom));
          made++;
        end else begin
          // mostly short distances so copies hit recently decoded data
          case ($urandom_range(0, 9))
            0:       offset = 12'h000;
            1:       offset = 12'hfff;
            2:       offset = 12'($urandom);
            default: offset = 12'($urandom_range(1, 24));
          endcase
          span = 4'($urandom);
          stream_q.push_back(offset[7:0]);
          stream_q.push_back({span, offset[11:8]});
          made += span + 3;
        end
      end
    end
  endfunction

  initial begin
    int random_sent;
    int kind;
    int cut;
    int unsigned total;
    rst_n              = 1'b0;
    calm               = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.stream_start = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // header without start mark; literals, max-length copies at distance 2,
    // distance 0 and 4095, the last cut at the declared length, trailing byte
    stream_q = '{8'h2a, 8'h00, 8'h00, 8'h00, 8'hfa, 8'h80, 8'h02, 8'hf0, 8'h7f,
                 8'h00, 8'hf0, 8'hff, 8'hff, 8'h33};
    play_stream(1'b0, stream_q.size());
    // zero declared length, then a byte that must be swallowed
    stream_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h5a};
    play_stream(1'b1, stream_q.size());
    // largest declared length, abandoned by the next start mark
    stream_q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h7e};
    play_stream(1'b1, stream_q.size());
    // restart in the middle of a header
    stream_q = '{8'h11, 8'h22};
    play_stream(1'b1, stream_q.size());
    drain();

    random_sent = 0;
    while (random_sent < 100) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        stream_q.delete();
        repeat ($urandom_range(3, 12)) stream_q.push_back(8'($urandom));
        play_stream(1'b1, stream_q.size());
        random_sent += stream_q.size();
      end else begin
        if ($urandom_range(0, 15) == 0) total = $urandom_range(150, 300);
        else if ($urandom_range(0, 19) == 0) total = 0;
        else total = $urandom_range(1, 60);
        build_stream(total);
        // a broken stream stops anywhere and is cut off by the next start
        cut = (kind == 1) ? $urandom_range(1, stream_q.size()) : stream_q.size();
        play_stream(1'b1, cut);
        random_sent += cut;
        if (kind == 2) begin
          stream_q = '{8'($urandom), 8'($urandom)};
          play_stream(1'b0, 2);
        end
      end
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS lzss_ring_window_decompressor");
    end else begin
      $display("FAIL lzss_ring_window_decompressor");
    end
    $finish;
  end

endmodule

// ===== lzss_ring_window_decompressor.f =====
+incdir+rtl
rtl/lzss_pkg.sv
rtl/lzss_if.sv
rtl/lzss_ctrl.sv
rtl/lzss_dp.sv
rtl/lzss_ring_window_decompressor.sv
bench/lzss_ring_window_decompressor_chk.sv
bench/lzss_ring_window_decompressor_tb.sv
